// File: hdl/bsdf_pkg.sv
// Shared constants, command and status types and bit search helpers.
package bsdf_pkg;

	localparam int SUPERSAMPLE   = 64;
	localparam int GLYPH_PIXELS  = 16;
	localparam int BORDER_PIXELS = 4;
	localparam int RADIUS_PIXELS = 5;
	localparam int LO_SIDE       = GLYPH_PIXELS + 2 * BORDER_PIXELS;
	localparam int HI_SIDE       = LO_SIDE * SUPERSAMPLE;
	localparam int ROW_WORDS     = (HI_SIDE + 63) / 64;
	localparam int MAP_WORDS     = ROW_WORDS * HI_SIDE;
	localparam int RADIUS        = RADIUS_PIXELS * SUPERSAMPLE;
	localparam int RADIUS_SQ     = RADIUS * RADIUS;
	localparam int SQRT_STEPS    = 16;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic              wr_en;
		logic              load;
		logic              rd;
		logic              samp;
		logic [1:0]        sy;
		logic signed [9:0] dy;
		logic signed [3:0] k;
		logic              row_end;
		logic              mul;
		logic              sqrt_init;
		logic              sqrt_step;
		logic              fin;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic logic [5:0] hi_bit(input logic [63:0] v);
		logic [5:0] idx;
		idx = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) idx = 6'(i);
		end
		return idx;
	endfunction

	function automatic logic [5:0] lo_bit(input logic [63:0] v);
		logic [5:0] idx;
		idx = '0;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) idx = 6'(i);
		end
		return idx;
	endfunction

endpackage

// File: hdl/bsdf_ctrl.sv
// Controller state machine that sequences sampling, scanning and the square root.
module bsdf_ctrl import bsdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_kind,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SAMP  = 3'd1;
	localparam logic [2:0] ST_SWAIT = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_SQRT  = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	localparam logic signed [9:0] DY_FIRST = -10'(RADIUS);
	localparam logic signed [9:0] DY_LAST  = 10'(RADIUS);
	localparam logic signed [3:0] K_FIRST  = -4'(RADIUS_PIXELS);
	localparam logic signed [3:0] K_LAST   = 4'(RADIUS_PIXELS);

	logic [2:0]        state_q;
	logic [1:0]        sy_q;
	logic signed [9:0] dy_q;
	logic signed [3:0] k_q;
	logic [3:0]        cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.sy        = sy_q;
		cmd.dy        = dy_q;
		cmd.k         = k_q;
		cmd.row_end   = (k_q == K_LAST);
		cmd.wr_en     = in_ready && in_valid && (in_kind == KIND_WRITE);
		cmd.load      = in_ready && in_valid && (in_kind == KIND_QUERY);
		cmd.rd        = (state_q == ST_SAMP) || (state_q == ST_SCAN);
		cmd.samp      = (state_q == ST_SAMP);
		cmd.mul       = (state_q == ST_MUL);
		cmd.sqrt_init = (state_q == ST_MUL);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.fin       = (state_q == ST_FIN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sy_q    <= '0;
			dy_q    <= DY_FIRST;
			k_q     <= K_FIRST;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_SAMP;
						sy_q    <= '0;
					end
				end
				ST_SAMP: begin
					sy_q <= sy_q + 2'd1;
					if (sy_q == 2'd3) begin
						state_q <= ST_SWAIT;
						cnt_q   <= '0;
					end
				end
				ST_SWAIT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd3) begin
						state_q <= ST_SCAN;
						dy_q    <= DY_FIRST;
						k_q     <= K_FIRST;
					end
				end
				ST_SCAN: begin
					if (k_q == K_LAST) begin
						k_q <= K_FIRST;
						dy_q <= dy_q + 10'sd1;
						if (dy_q == DY_LAST) begin
							state_q <= ST_DRAIN;
							cnt_q   <= '0;
						end
					end else begin
						k_q <= k_q + 4'sd1;
					end
				end
				ST_DRAIN: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd7) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SQRT;
					cnt_q   <= '0;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(SQRT_STEPS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/bsdf_dp.sv
// Datapath: bitmap memory, sample count, nearest-bit search, square root and code.
module bsdf_dp import bsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [95:0] in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_data
);

	logic [63:0] mem [0:MAP_WORDS-1];

	logic [4:0]  px_q, py_q;
	logic [4:0]  cnt_q;
	logic        in_glyph;

	// Read address.
	logic signed [12:0] y_c;
	logic signed [6:0]  w_c;
	logic               oob_c;
	logic [15:0]        raddr_c;
	logic [15:0]        waddr_c;

	// Memory read stage.
	logic [63:0]       rdata_s1;
	logic              v_s1, samp_s1, oob_s1, row_end_s1;
	logic signed [3:0] k_s1;
	logic signed [9:0] dy_s1;

	// Candidate stage.
	logic [9:0]        m_s2;
	logic              hit_s2, v_s2, row_end_s2;
	logic signed [9:0] dy_s2;
	logic [9:0]        rmin_q;
	logic              rhit_q;

	logic [8:0]        row_m_s3;
	logic              hit_s3, v_s3;
	logic [8:0]        dya_s3;
	logic [17:0]       mm_s4, dd_s4;
	logic              hit_s4;
	logic [17:0]       d2_c;
	logic [16:0]       best_q;

	logic [31:0] n_q;
	logic [16:0] rem_q;
	logic [15:0] root_q;

	logic        out_valid_q;
	logic [7:0]  code_q;
	logic        inside_out_q;

	assign in_glyph = (cnt_q >= 5'd8);

	always_comb begin
		if (cmd.samp) begin
			y_c = 13'(signed'({1'b0, py_q, 6'b0})) + 13'(signed'({1'b0, cmd.sy, 4'b1000}));
			w_c = 7'(signed'({1'b0, px_q}));
		end else begin
			y_c = 13'(signed'({1'b0, py_q, 6'b0})) + 13'sd32 + 13'(cmd.dy);
			w_c = 7'(signed'({1'b0, px_q})) + 7'(cmd.k);
		end
		oob_c = (y_c < 0) || (y_c >= 13'sd1536) || (w_c < 0) || (w_c >= 7'sd24);
		raddr_c = oob_c ? 16'd0 : 16'({y_c[10:0], 4'b0}) + 16'({y_c[10:0], 3'b0})
			+ 16'(w_c[4:0]);
		waddr_c = in_data[15:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && (waddr_c < 16'(MAP_WORDS))) mem[waddr_c] <= in_data[79:16];
		rdata_s1 <= mem[raddr_c];
	end

	// Nearest opposite bit within one word.
	logic [63:0] opp, mask_r, mask_l;
	logic [2:0]  kabs;
	logic [9:0]  mr, ml, mc;
	logic        hr, hl, hc;

	always_comb begin
		opp = oob_s1 ? (in_glyph ? '1 : '0) : (in_glyph ? ~rdata_s1 : rdata_s1);
		kabs = k_s1[3] ? 3'(-k_s1) : k_s1[2:0];
		if (k_s1 > 0) begin
			mask_r = opp;
			mask_l = '0;
		end else if (k_s1 < 0) begin
			mask_r = '0;
			mask_l = opp;
		end else begin
			mask_r = opp & 64'h0000_0000_FFFF_FFFF;
			mask_l = opp & 64'hFFFF_FFFF_0000_0000;
		end
		mr = {1'b0, kabs, 6'b0} + 10'd31 - 10'(hi_bit(mask_r));
		ml = {1'b0, kabs, 6'b0} + 10'(lo_bit(mask_l)) - 10'd31;
		hr = (|mask_r) && (mr <= 10'(RADIUS));
		hl = (|mask_l) && (ml <= 10'(RADIUS));
		if (hr && (!hl || mr <= ml)) begin
			mc = mr;
			hc = 1'b1;
		end else begin
			mc = ml;
			hc = hl;
		end
	end

	// Row minimum merged with the current candidate.
	logic [9:0] rcur;
	logic       rcur_hit;
	always_comb begin
		if (hit_s2 && (!rhit_q || m_s2 < rmin_q)) begin
			rcur = m_s2;
			rcur_hit = 1'b1;
		end else begin
			rcur = rmin_q;
			rcur_hit = rhit_q;
		end
	end

	assign d2_c = mm_s4 + dd_s4;

	// Integer square root, two radicand bits and one root bit per step.
	logic [18:0] r2, trial;
	always_comb begin
		r2    = {rem_q, n_q[31:30]};
		trial = {1'b0, root_q, 2'b01};
	end

	// Division by the radius as a shift and a reciprocal multiply by five.
	logic [16:0] qin_p;
	logic [16:0] top, tsum;
	logic [17:0] qout_p;
	logic [7:0]  kdiv, code_c;
	always_comb begin
		qin_p  = 17'(root_q[15:6] * 8'd205);
		top    = 17'(root_q) + 17'(rem_q != '0);
		tsum   = top + 17'd319;
		qout_p = 18'(tsum[16:6] * 8'd205);
		kdiv   = qout_p[17:10];
		if (in_glyph) code_c = 8'd128 + 8'(qin_p[16:10]);
		else if (kdiv > 8'd128) code_c = 8'd0;
		else code_c = 8'd128 - kdiv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			hit_s4      <= 1'b0;
			rhit_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			best_q      <= 17'(RADIUS_SQ);
		end else begin
			v_s1 <= cmd.rd;
			v_s2 <= v_s1 && !samp_s1;
			if (cmd.load) begin
				cnt_q  <= '0;
				best_q <= 17'(RADIUS_SQ);
			end else if (v_s1 && samp_s1 && !oob_s1) begin
				cnt_q <= cnt_q + 5'(rdata_s1[55]) + 5'(rdata_s1[39]) + 5'(rdata_s1[23])
					+ 5'(rdata_s1[7]);
			end
			v_s3 <= v_s2 && row_end_s2;
			if (v_s2) begin
				if (row_end_s2) rhit_q <= 1'b0;
				else rhit_q <= rcur_hit;
			end
			hit_s4 <= v_s3 && hit_s3;
			if (hit_s4 && (d2_c < 18'(best_q))) best_q <= d2_c[16:0];
			if (cmd.fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		samp_s1    <= cmd.samp;
		oob_s1     <= oob_c;
		k_s1       <= cmd.k;
		dy_s1      <= cmd.dy;
		row_end_s1 <= cmd.row_end;
		m_s2       <= mc;
		hit_s2     <= hc;
		dy_s2      <= dy_s1;
		row_end_s2 <= row_end_s1;
		if (v_s2 && !row_end_s2) rmin_q <= rcur;
		row_m_s3   <= rcur[8:0];
		hit_s3     <= rcur_hit;
		dya_s3     <= dy_s2[9] ? 9'(-dy_s2) : dy_s2[8:0];
		mm_s4      <= row_m_s3 * row_m_s3;
		dd_s4      <= dya_s3 * dya_s3;
		if (cmd.load) begin
			px_q <= in_data[84:80];
			py_q <= in_data[89:85];
		end
		if (cmd.mul) n_q <= {1'b0, 31'(best_q * 14'd16129)};
		if (cmd.sqrt_init) begin
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			n_q <= {n_q[29:0], 2'b00};
			if (r2 >= trial) begin
				rem_q  <= 17'(r2 - trial);
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				rem_q  <= r2[16:0];
				root_q <= {root_q[14:0], 1'b0};
			end
		end
		if (cmd.fin) begin
			code_q       <= code_c;
			inside_out_q <= in_glyph;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = {7'b0, inside_out_q, code_q};

	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= 17'(RADIUS_SQ)) else $error("best distance above radius squared");
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!out_valid_q || out_ready)) else $error("result overwritten");
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && hit_s3) |-> (row_m_s3 <= 9'(RADIUS))) else $error("row hit beyond radius");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'd16) else $error("sample count overflow");

endmodule

// File: hdl/bitmap_signed_distance_field.sv
// Signed distance field block over a stored supersampled glyph bitmap.
// Input channel s_*: s_tuser selects the kind of word: 0 writes one 64-bit
// bitmap word, 1 queries one low-resolution pixel. A write is stored and
// gives no result. A query gives one result word on m_*.
// A query reads four sample rows, then scans 641 bitmap rows of 11 words,
// one memory word per cycle through the single read port, then runs a
// 16-step square root. Only one query is in work at a time; s_tready is
// low while it runs.
// The result sits in an output register. While the receiver stalls the
// block still accepts writes and the next query, and a finished query waits
// until the previous result has been taken.
// After reset the control state is idle and no result is pending; the
// bitmap contents are undefined until written.
module bitmap_signed_distance_field import bsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// word_addr[15:0], word_bits[79:16], pixel_x[84:80], pixel_y[89:85]
	input  logic [95:0] s_tdata,
	// kind[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// distance_code[7:0], is_inside[8]
	output logic [15:0] m_tdata
);

	cmd_t cmd;
	sts_t sts;

	bsdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsdf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
